// ----- rtl/sbq_pkg.sv -----
// Package for the stereo biquad filter core: widths, register indexes and
// the control types shared by the top level and the multiply-accumulate unit.
// Depends on nothing.
package sbq_pkg;

    // Field and storage widths.
    localparam int CHANNELS     = 2;
    localparam int CH_BITS      = 1;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 18;
    localparam int COEF_FRAC    = COEF_BITS - 3;
    localparam int DELAY_BITS   = 32;
    localparam int PROD_BITS    = COEF_BITS + DELAY_BITS;
    localparam int ACC_BITS     = PROD_BITS + 3;
    localparam int NUM_REGS     = 5;
    localparam int REG_IDX_BITS = 3;

    // Coefficient register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd4;

    // Reset value of b0 is 1.0 in Q2.15.
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

    // Accumulator operations of the shared unit.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    // Control word from the sequencer to the shared unit.
    typedef struct packed {
        logic    mul_en;
        t_acc_op op;
    } t_mac_ctl;

endpackage

// ----- rtl/sbq_if.sv -----
// Valid/ready channel interfaces for the stereo biquad filter core:
// sample input, sample output and coefficient writes. Depends on sbq_pkg.

// Sample input channel.
interface sbq_in_if;
    import sbq_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic        [CH_BITS-1:0]     channel;

    modport source (output valid, output sample_in, output channel, input ready);
    modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// Filtered sample output channel.
interface sbq_out_if;
    import sbq_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic        [CH_BITS-1:0]     channel_out;

    modport source (output valid, output sample_out, output channel_out, input ready);
    modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

// Coefficient write channel.
interface sbq_cfg_if;
    import sbq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [REG_IDX_BITS-1:0] index;
    logic [COEF_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sbq_mac.sv -----
// Shared multiply-accumulate unit of the stereo biquad filter core: one
// registered 18x32 signed multiplier feeding a 53-bit accumulator.
// Depends on sbq_pkg.
module sbq_mac (
    input  logic                                  i_clk,
    input  sbq_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [sbq_pkg::COEF_BITS-1:0]  i_coef,
    input  logic signed [sbq_pkg::DELAY_BITS-1:0] i_opnd,
    input  logic signed [sbq_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [sbq_pkg::ACC_BITS-1:0]   o_acc
);
    import sbq_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  x_ext;

    // Product and input sample brought to the accumulator scale.
    assign prod_ext = {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    assign x_ext    = {{(ACC_BITS-SAMPLE_BITS-COEF_FRAC){i_sample[SAMPLE_BITS-1]}},
                       i_sample, {COEF_FRAC{1'b0}}};

    // Accumulator update selected by the sequencer.
    always_comb begin
        case (i_ctl.op)
            ACC_HOLD:   n_acc = r_acc;
            ACC_LOAD_X: n_acc = x_ext;
            ACC_LOAD_P: n_acc = prod_ext;
            ACC_ADD:    n_acc = r_acc + prod_ext;
            ACC_SUB:    n_acc = r_acc - prod_ext;
            default:    n_acc = r_acc;
        endcase
    end

    // The product is registered before it reaches the adder.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_opnd;
        end
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/stereo_biquad_iir_filter_core.sv -----
// Top level of the stereo biquad filter core: coefficient registers, delay
// words, sequencer and output register. Depends on sbq_pkg, sbq_if, sbq_mac.

// Direct form II biquad for interleaved channels. Each accepted sample takes
// the transfer cycle, then seven steps in which the single shared
// 18x32 multiplier and accumulator compute the five products in turn (the
// multiplier result is registered, so each product is accumulated in the cycle after
// it is issued, and the b0 product waits for the rounded w0). The input is
// ready again once the result is loaded into the output register; a result that
// is not taken holds the last step until the register frees. Coefficients are
// written at any time through the write channel, which is always ready, but
// should change only while no sample is in flight. There is no clearing pass.
module stereo_biquad_iir_filter_core (
    input  logic i_clk,
    input  logic i_rst_n,
    sbq_cfg_if.sink   i_cfg,
    sbq_in_if.sink    i_smp,
    sbq_out_if.source o_smp
);
    import sbq_pkg::*;

    localparam logic [2:0] STEP_LAST = 3'd6;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                          r_state;
    logic [2:0]                      r_step;
    logic [COEF_BITS-1:0]            r_coef [NUM_REGS];
    logic [CHANNELS-1:0][DELAY_BITS-1:0] r_w1;
    logic [CHANNELS-1:0][DELAY_BITS-1:0] r_w2;
    logic signed [SAMPLE_BITS-1:0]   r_x;
    logic [CH_BITS-1:0]              r_ch;
    logic                            r_ch_ok;
    logic signed [DELAY_BITS-1:0]    r_cur_w1;
    logic signed [DELAY_BITS-1:0]    r_cur_w2;
    logic signed [DELAY_BITS-1:0]    r_w0;
    logic                            r_out_valid;
    logic signed [SAMPLE_BITS-1:0]   r_out_sample;
    logic [CH_BITS-1:0]              r_out_ch;

    t_mac_ctl                        mac_ctl;
    logic signed [COEF_BITS-1:0]     mul_coef;
    logic signed [DELAY_BITS-1:0]    mul_opnd;
    logic signed [ACC_BITS-1:0]      acc;
    logic signed [ACC_BITS-1:0]      acc_rnd;
    logic signed [DELAY_BITS-1:0]    w0_sat;
    logic signed [SAMPLE_BITS-1:0]   y_sat;
    logic                            in_xfer;
    logic                            last_go;

    assign i_cfg.ready = 1'b1;

    // Input is taken only between samples.
    assign i_smp.ready = (r_state == S_IDLE);
    assign in_xfer     = i_smp.valid && i_smp.ready;

    // The last step finishes only when the output register is free.
    assign last_go = (r_state == S_RUN) && (r_step == STEP_LAST)
                     && (!r_out_valid || o_smp.ready);

    // Coefficient registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_A1] <= '0;
            r_coef[REG_A2] <= '0;
            r_coef[REG_B0] <= COEF_ONE;
            r_coef[REG_B1] <= '0;
            r_coef[REG_B2] <= '0;
        end else if (i_cfg.valid && i_cfg.ready && (32'(i_cfg.index) < NUM_REGS)) begin
            r_coef[i_cfg.index] <= i_cfg.data;
        end
    end

    // Per-step operand selection and accumulator operation. The held sample
    // is loaded in the first step, once it sits in its register.
    always_comb begin
        mac_ctl.mul_en = 1'b0;
        mac_ctl.op     = ACC_HOLD;
        mul_coef       = $signed(r_coef[REG_A1]);
        mul_opnd       = r_cur_w1;
        if (r_state == S_RUN) begin
            case (r_step)
                3'd0: begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.op     = ACC_LOAD_X;
                    mul_coef       = $signed(r_coef[REG_A1]);
                    mul_opnd       = r_cur_w1;
                end
                3'd1: begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.op     = ACC_SUB;
                    mul_coef       = $signed(r_coef[REG_A2]);
                    mul_opnd       = r_cur_w2;
                end
                3'd2: begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.op     = ACC_SUB;
                    mul_coef       = $signed(r_coef[REG_B1]);
                    mul_opnd       = r_cur_w1;
                end
                3'd3: begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.op     = ACC_LOAD_P;
                    mul_coef       = $signed(r_coef[REG_B2]);
                    mul_opnd       = r_cur_w2;
                end
                3'd4: begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.op     = ACC_ADD;
                    mul_coef       = $signed(r_coef[REG_B0]);
                    mul_opnd       = r_w0;
                end
                3'd5: begin
                    mac_ctl.op = ACC_ADD;
                end
                default: begin
                    mac_ctl.op = ACC_HOLD;
                end
            endcase
        end
    end

    sbq_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_coef   (mul_coef),
        .i_opnd   (mul_opnd),
        .i_sample (r_x),
        .o_acc    (acc)
    );

    // Round half up back to the sample scale, then saturate to each range.
    assign acc_rnd = (acc + (ACC_BITS'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;

    always_comb begin
        if ((&acc_rnd[ACC_BITS-1:DELAY_BITS-1]) || !(|acc_rnd[ACC_BITS-1:DELAY_BITS-1])) begin
            w0_sat = acc_rnd[DELAY_BITS-1:0];
        end else begin
            w0_sat = {acc_rnd[ACC_BITS-1], {(DELAY_BITS-1){~acc_rnd[ACC_BITS-1]}}};
        end
        if ((&acc_rnd[ACC_BITS-1:SAMPLE_BITS-1]) || !(|acc_rnd[ACC_BITS-1:SAMPLE_BITS-1])) begin
            y_sat = acc_rnd[SAMPLE_BITS-1:0];
        end else begin
            y_sat = {acc_rnd[ACC_BITS-1], {(SAMPLE_BITS-1){~acc_rnd[ACC_BITS-1]}}};
        end
    end

    // Sequencer, delay words and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_w1        <= '0;
            r_w2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (last_go) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.valid && o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state  <= S_RUN;
                        r_step   <= '0;
                        r_x      <= i_smp.sample_in;
                        r_ch     <= i_smp.channel;
                        r_ch_ok  <= (32'(i_smp.channel) < CHANNELS);
                        r_cur_w1 <= $signed(r_w1[i_smp.channel]);
                        r_cur_w2 <= $signed(r_w2[i_smp.channel]);
                    end
                end
                S_RUN: begin
                    if (r_step == 3'd3) begin
                        r_w0 <= w0_sat;
                    end
                    if (r_step != STEP_LAST) begin
                        r_step <= r_step + 3'd1;
                    end else if (last_go) begin
                        r_state      <= S_IDLE;
                        r_out_ch     <= r_ch;
                        r_out_sample <= r_ch_ok ? y_sat : '0;
                        if (r_ch_ok) begin
                            r_w2[r_ch] <= r_cur_w1;
                            r_w1[r_ch] <= r_w0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_smp.valid       = r_out_valid;
    assign o_smp.sample_out  = r_out_sample;
    assign o_smp.channel_out = r_out_ch;

`ifndef SYNTHESIS
    // A sample transfer is followed by a busy period in which the input is not ready.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("input ready right after a sample transfer");

    // Delay words change only when a sample completes.
    a_delay_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !last_go |=> ($stable(r_w1) && $stable(r_w2)))
        else $error("delay words changed outside the final step");

    // The step counter never runs past the final step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= STEP_LAST))
        else $error("step counter out of range");

    // A completed sample always lands in the output register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_go |=> o_smp.valid)
        else $error("completed sample not presented at the output");
`endif

endmodule
